[hdl/pic_pkg.sv]
// Shared types, constants and saturating Q8.24 helpers for the pedigree
// inbreeding block. No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

  localparam int VAL_W     = 32;
  localparam int FRAC_W    = 24;
  localparam int IDX_IN_W  = 13;
  localparam int GRP_W     = 12;
  localparam int ROW_OUT_W = 12;
  localparam int CFG_IDX_W = 8;

  localparam int DEF_MAX_ROWS       = 4096;
  localparam int DEF_ANCESTOR_SLOTS = 8192;

  localparam logic signed [VAL_W-1:0] VMAX   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VMIN   = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] Q_ONE  = 32'sh0100_0000;
  localparam logic signed [VAL_W-1:0] Q_HALF = 32'sh0080_0000;
  localparam logic signed [VAL_W-1:0] Q_MINUS_ONE = 32'shFF00_0000;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_INDIVIDUAL_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPUTE_F        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_PARENT_F = 8'd3;

  localparam logic [IDX_IN_W-1:0]     IC_RESET  = 13'd4096;
  localparam logic signed [VAL_W-1:0] UPF_RESET = Q_MINUS_ONE;

  typedef struct packed {
    logic [IDX_IN_W-1:0]     dam_index;
    logic [IDX_IN_W-1:0]     sire_index;
    logic signed [VAL_W-1:0] given_f;
  } row_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0]    row_index;
    logic signed [VAL_W-1:0] f_value;
    logic signed [VAL_W-1:0] dii_value;
    logic                    bad_parent;
  } res_t;

  typedef struct packed {
    logic [IDX_IN_W-1:0]     individual_count;
    logic [GRP_W-1:0]        group_count;
    logic                    compute_f;
    logic signed [VAL_W-1:0] unknown_parent_f;
  } cfg_t;

  function automatic logic signed [VAL_W-1:0] sat_add(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b
  );
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? VMIN : VMAX;
    end
    return s[VAL_W-1:0];
  endfunction

  // Halve, truncated toward zero
  function automatic logic signed [VAL_W-1:0] half_tz(input logic signed [VAL_W-1:0] x);
    logic signed [VAL_W-1:0] t;
    t = x + VAL_W'(x[VAL_W-1]);
    return t >>> 1;
  endfunction

  // Quarter, truncated toward zero
  function automatic logic signed [VAL_W-1:0] quarter_tz(input logic signed [VAL_W-1:0] x);
    logic signed [VAL_W-1:0] t;
    t = x + (x[VAL_W-1] ? VAL_W'(3) : VAL_W'(0));
    return t >>> 2;
  endfunction

endpackage

`default_nettype wire

[hdl/pedigree_inbreeding_coefficients.sv]
// Top level of the pedigree inbreeding block: configuration registers, input
// request handshake and result register around pic_core. Uses pic_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Pedigree rows come in one request at a time, parents before offspring; each
// request gets one result with the row number, its Q8.24 inbreeding value f,
// its Mendelian sampling factor dii and a bad-parent flag. After reset the
// block sweeps its path-weight store before it takes the first request
// (configuration writes are taken throughout). A group row, a row with
// compute_f at 0 and a full sib of the previous row skip the ancestor walk.
// In a walk, each ancestor it visits costs up to two path-weight
// read-modify-writes, two passes through the shared multiplier and at most
// one scan of the ancestor list to find the highest-numbered (youngest)
// entry, and the walk ends with a sweep that zeroes the path weights of
// rows up to the current one. The block holds row_stall high while a row
// is in work; a finished result waits in the output register, so the next
// request is taken while that result is still stalled.
module pedigree_inbreeding_coefficients import pic_pkg::*; #(
  parameter int MAX_ROWS       = DEF_MAX_ROWS,
  parameter int ANCESTOR_SLOTS = DEF_ANCESTOR_SLOTS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    row_valid,
  output logic                    row_stall,
  input  row_t                    row_data,
  output logic                    res_valid,
  input  logic                    res_stall,
  output res_t                    res_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [VAL_W-1:0]        cfg_data
);

  cfg_t cfg;
  logic core_ready;
  logic core_done;
  logic take;
  res_t core_res;

  // Configuration writes are always accepted; writes past the list drop
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.individual_count <= IC_RESET;
      cfg.group_count      <= '0;
      cfg.compute_f        <= 1'b1;
      cfg.unknown_parent_f <= UPF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INDIVIDUAL_COUNT: cfg.individual_count <= cfg_data[IDX_IN_W-1:0];
        CFG_GROUP_COUNT:      cfg.group_count      <= cfg_data[GRP_W-1:0];
        CFG_COMPUTE_F:        cfg.compute_f        <= cfg_data[0];
        CFG_UNKNOWN_PARENT_F: cfg.unknown_parent_f <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Hold off requests while the sequencer is busy or sweeping after reset
  assign row_stall = !core_ready;

  // Advance a finished result into the output register when it is free
  assign take = core_done && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_data <= core_res;
    end
  end

  pic_core #(
    .MAX_ROWS       (MAX_ROWS),
    .ANCESTOR_SLOTS (ANCESTOR_SLOTS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (row_valid && !row_stall),
    .req   (row_data),
    .ready (core_ready),
    .done  (core_done),
    .take  (take),
    .res   (core_res)
  );

endmodule

`default_nettype wire

[hdl/pic_mul.sv]
// Shared Q8.24 multiplier: magnitude product registered, then truncation
// toward zero and saturation registered. Uses pic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pic_mul import pic_pkg::*; (
  input  logic                    clk,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  output logic signed [VAL_W-1:0] res
);

  localparam int R_W = 2 * VAL_W - FRAC_W;

  logic [VAL_W-1:0]   ua;
  logic [VAL_W-1:0]   ub;
  logic               neg;
  logic [2*VAL_W-1:0] prod;
  logic [R_W-1:0]     r;
  logic [R_W-1:0]     lim;

  assign ua  = a[VAL_W-1] ? (~a + 1'b1) : a;
  assign ub  = b[VAL_W-1] ? (~b + 1'b1) : b;
  assign r   = prod[2*VAL_W-1:FRAC_W];
  assign lim = neg ? R_W'({1'b1, {(VAL_W-1){1'b0}}}) : R_W'({1'b0, {(VAL_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    neg  <= a[VAL_W-1] ^ b[VAL_W-1];
    prod <= ua * ub;
    if (r > lim) begin
      res <= neg ? VMIN : VMAX;
    end else begin
      res <= neg ? -$signed(r[VAL_W-1:0]) : $signed(r[VAL_W-1:0]);
    end
  end

endmodule

`default_nettype wire

[hdl/pic_core.sv]
// Row store and ancestor-walk sequencer: pedigree memories, ancestor list and
// path weights, driving the shared multiplier pic_mul. Uses pic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pic_core import pic_pkg::*; #(
  parameter int MAX_ROWS       = DEF_MAX_ROWS,
  parameter int ANCESTOR_SLOTS = DEF_ANCESTOR_SLOTS
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic start,
  input  row_t req,
  output logic ready,
  output logic done,
  input  logic take,
  output res_t res
);

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int IDX_W = $clog2(MAX_ROWS + 1);
  localparam int AW    = $clog2(ANCESTOR_SLOTS);
  localparam int CW    = $clog2(ANCESTOR_SLOTS + 1);
  localparam logic [IDX_W-1:0] NOP       = IDX_W'(MAX_ROWS);
  localparam logic [31:0]      LIMIT_MAX = 32'(MAX_ROWS);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(MAX_ROWS - 1);
  localparam logic [CW-1:0]    SLOTS     = CW'(ANCESTOR_SLOTS);

  typedef enum logic [21:0] {
    ST_RST_CLR   = 22'h000001,
    ST_IDLE      = 22'h000002,
    ST_PREP      = 22'h000004,
    ST_RD_FD     = 22'h000008,
    ST_RD_FS     = 22'h000010,
    ST_DII       = 22'h000020,
    ST_SIB       = 22'h000040,
    ST_WALK_INIT = 22'h000080,
    ST_NODE_RD   = 22'h000100,
    ST_NODE_DATA = 22'h000200,
    ST_Q_RD      = 22'h000400,
    ST_Q_UPD     = 22'h000800,
    ST_M1        = 22'h001000,
    ST_M1W       = 22'h002000,
    ST_M2        = 22'h004000,
    ST_M2W       = 22'h008000,
    ST_ACC       = 22'h010000,
    ST_SCAN      = 22'h020000,
    ST_POP       = 22'h040000,
    ST_CLEAR     = 22'h080000,
    ST_FIN_WRITE = 22'h100000,
    ST_DONE      = 22'h200000
  } state_t;

  state_t state;

  logic [ROW_W-1:0]        row_counter;
  logic [ROW_W-1:0]        k;
  row_t                    req_q;
  logic [IDX_W-1:0]        dam;
  logic [IDX_W-1:0]        sire;
  logic                    bad;
  logic signed [VAL_W-1:0] f;
  logic signed [VAL_W-1:0] dii;
  logic signed [VAL_W-1:0] fd;
  logic signed [VAL_W-1:0] fsum;
  logic signed [VAL_W-1:0] acc;
  logic signed [VAL_W-1:0] w;
  logic signed [VAL_W-1:0] var_n;
  logic [IDX_W-1:0]        sire_n;
  logic [IDX_W-1:0]        dam_n;
  logic [ROW_W-1:0]        j;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           scan_i;
  logic [ROW_W-1:0]        best_val;
  logic [AW-1:0]           best_pos;
  logic [ROW_W-1:0]        last;
  logic [ROW_W-1:0]        ptr;
  logic                    phase;

  // Memories
  logic [IDX_W-1:0]        dam_mem   [MAX_ROWS];
  logic [IDX_W-1:0]        sire_mem  [MAX_ROWS];
  logic signed [VAL_W-1:0] var_mem   [MAX_ROWS];
  logic signed [VAL_W-1:0] inb_mem   [MAX_ROWS];
  logic signed [VAL_W-1:0] pw_mem    [MAX_ROWS];
  logic                    inl_mem   [MAX_ROWS];
  logic [ROW_W-1:0]        alist_mem [ANCESTOR_SLOTS];

  logic [IDX_W-1:0]        dam_rd;
  logic [IDX_W-1:0]        sire_rd;
  logic signed [VAL_W-1:0] var_rd;
  logic signed [VAL_W-1:0] inb_rd;
  logic signed [VAL_W-1:0] pw_rd;
  logic                    inl_rd;
  logic [ROW_W-1:0]        alist_rd;

  logic                    row_we;
  logic [ROW_W-1:0]        row_ra;
  logic [IDX_W-1:0]        dam_wd;
  logic [IDX_W-1:0]        sire_wd;
  logic signed [VAL_W-1:0] var_wd;
  logic                    inb_we;
  logic [ROW_W-1:0]        inb_ra;
  logic signed [VAL_W-1:0] inb_wd;
  logic                    pw_we;
  logic [ROW_W-1:0]        pw_wa;
  logic [ROW_W-1:0]        pw_ra;
  logic signed [VAL_W-1:0] pw_wd;
  logic                    inl_we;
  logic [ROW_W-1:0]        inl_wa;
  logic                    inl_wd;
  logic                    al_we;
  logic [AW-1:0]           al_wa;
  logic [AW-1:0]           al_ra;
  logic [ROW_W-1:0]        al_wd;

  // Combinational helpers
  logic [31:0]             ic32;
  logic [31:0]             gc32;
  logic [31:0]             limit;
  logic [ROW_W-1:0]        k_start;
  logic [ROW_W-1:0]        rc_next;
  logic                    is_group;
  logic [IDX_W-1:0]        dam_cls;
  logic [IDX_W-1:0]        sire_cls;
  logic                    bad_cls;
  logic [IDX_W-1:0]        p;
  logic                    p_skip;
  logic                    push;
  logic signed [VAL_W-1:0] pw_sum;
  logic signed [VAL_W-1:0] dii_c;
  logic                    sib_ok;
  logic signed [VAL_W-1:0] mul_a;
  logic signed [VAL_W-1:0] mul_b;
  logic signed [VAL_W-1:0] mul_res;
  logic                    take_best;

  assign ic32  = 32'(cfg.individual_count);
  assign gc32  = 32'(cfg.group_count);
  assign limit = (ic32 == 32'd0) ? 32'd1 : ((ic32 > LIMIT_MAX) ? LIMIT_MAX : ic32);
  assign k_start = (32'(row_counter) >= limit) ? '0 : row_counter;
  assign rc_next = ((32'(k) + 32'd1) >= limit) ? '0 : ROW_W'(32'(k) + 32'd1);
  assign is_group = 32'(k) < gc32;
  assign sib_ok   = (k != '0) && (32'(k) >= gc32 + 32'd1);

  always_comb begin
    bad_cls = 1'b0;
    if (32'(req_q.dam_index) == ic32) begin
      dam_cls = NOP;
    end else if (32'(req_q.dam_index) < 32'(k)) begin
      dam_cls = IDX_W'(req_q.dam_index);
    end else begin
      dam_cls = NOP;
      bad_cls = 1'b1;
    end
    if (32'(req_q.sire_index) == ic32) begin
      sire_cls = NOP;
    end else if (32'(req_q.sire_index) < 32'(k)) begin
      sire_cls = IDX_W'(req_q.sire_index);
    end else begin
      sire_cls = NOP;
      bad_cls  = 1'b1;
    end
  end

  assign p      = phase ? dam_n : sire_n;
  assign p_skip = (p == NOP) || (32'(p) < gc32);
  assign push   = !inl_rd && (cnt < SLOTS);
  assign pw_sum = sat_add(pw_rd, half_tz(w));
  assign dii_c  = sat_add(Q_HALF, -quarter_tz(fsum));
  assign take_best = (scan_i == '0) || (alist_rd > best_val);

  // Memory port control
  always_comb begin
    row_we  = (state == ST_PREP && is_group) || (state == ST_DII);
    dam_wd  = (state == ST_PREP) ? NOP : dam;
    sire_wd = (state == ST_PREP) ? NOP : sire;
    var_wd  = (state == ST_PREP) ? '0 : dii_c;
    row_ra  = (state == ST_DII) ? (k - 1'b1) : j;

    inb_we = (state == ST_PREP && is_group) || (state == ST_FIN_WRITE);
    inb_wd = (state == ST_PREP) ? req_q.given_f : f;
    if (state == ST_PREP) begin
      inb_ra = dam_cls[ROW_W-1:0];
    end else if (state == ST_RD_FD) begin
      inb_ra = sire[ROW_W-1:0];
    end else begin
      inb_ra = k - 1'b1;
    end

    pw_we = (state == ST_WALK_INIT) || (state == ST_Q_UPD) ||
            (state == ST_CLEAR) || (state == ST_RST_CLR);
    if (state == ST_WALK_INIT) begin
      pw_wa = k;
      pw_wd = Q_ONE;
    end else if (state == ST_Q_UPD) begin
      pw_wa = p[ROW_W-1:0];
      pw_wd = pw_sum;
    end else begin
      pw_wa = ptr;
      pw_wd = '0;
    end
    pw_ra = (state == ST_Q_RD) ? p[ROW_W-1:0] : j;

    inl_we = (state == ST_Q_UPD && push) || (state == ST_CLEAR) || (state == ST_RST_CLR);
    inl_wa = (state == ST_Q_UPD) ? p[ROW_W-1:0] : ptr;
    inl_wd = (state == ST_Q_UPD);

    al_we = (state == ST_Q_UPD && push) || (state == ST_POP);
    al_wa = (state == ST_Q_UPD) ? cnt[AW-1:0] : best_pos;
    al_wd = (state == ST_Q_UPD) ? p[ROW_W-1:0] : last;
    al_ra = (state == ST_ACC) ? '0 : AW'(scan_i + 1'b1);

    mul_a = (state == ST_M2) ? mul_res : w;
    mul_b = (state == ST_M2) ? var_n : w;
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      dam_mem[k]  <= dam_wd;
      sire_mem[k] <= sire_wd;
      var_mem[k]  <= var_wd;
    end
    dam_rd  <= dam_mem[row_ra];
    sire_rd <= sire_mem[row_ra];
    var_rd  <= var_mem[row_ra];
  end

  always_ff @(posedge clk) begin
    if (inb_we) begin
      inb_mem[k] <= inb_wd;
    end
    inb_rd <= inb_mem[inb_ra];
  end

  always_ff @(posedge clk) begin
    if (pw_we) begin
      pw_mem[pw_wa] <= pw_wd;
    end
    pw_rd <= pw_mem[pw_ra];
  end

  always_ff @(posedge clk) begin
    if (inl_we) begin
      inl_mem[inl_wa] <= inl_wd;
    end
    inl_rd <= inl_mem[p[ROW_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (al_we) begin
      alist_mem[al_wa] <= al_wd;
    end
    alist_rd <= alist_mem[al_ra];
  end

  pic_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RST_CLR;
      row_counter <= '0;
      ptr         <= '0;
    end else begin
      unique case (state)
        ST_RST_CLR: begin
          ptr <= ptr + 1'b1;
          if (ptr == LAST_ROW) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            req_q <= req;
            k     <= k_start;
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          row_counter <= rc_next;
          if (is_group) begin
            f     <= req_q.given_f;
            dii   <= '0;
            bad   <= 1'b0;
            state <= ST_DONE;
          end else begin
            dam   <= dam_cls;
            sire  <= sire_cls;
            bad   <= bad_cls;
            state <= ST_RD_FD;
          end
        end
        ST_RD_FD: begin
          fd    <= (dam == NOP) ? cfg.unknown_parent_f : inb_rd;
          state <= ST_RD_FS;
        end
        ST_RD_FS: begin
          fsum  <= sat_add(fd, (sire == NOP) ? cfg.unknown_parent_f : inb_rd);
          state <= ST_DII;
        end
        ST_DII: begin
          dii <= dii_c;
          if (!cfg.compute_f) begin
            f     <= req_q.given_f;
            state <= ST_FIN_WRITE;
          end else if (sib_ok) begin
            state <= ST_SIB;
          end else begin
            state <= ST_WALK_INIT;
          end
        end
        ST_SIB: begin
          // Full sib of the previous row: reuse its f
          if (dam_rd == dam && sire_rd == sire) begin
            f     <= inb_rd;
            state <= ST_FIN_WRITE;
          end else begin
            state <= ST_WALK_INIT;
          end
        end
        ST_WALK_INIT: begin
          j     <= k;
          cnt   <= '0;
          acc   <= '0;
          state <= ST_NODE_RD;
        end
        ST_NODE_RD: begin
          state <= ST_NODE_DATA;
        end
        ST_NODE_DATA: begin
          w      <= pw_rd;
          var_n  <= var_rd;
          sire_n <= sire_rd;
          dam_n  <= dam_rd;
          phase  <= 1'b0;
          state  <= ST_Q_RD;
        end
        ST_Q_RD: begin
          if (!p_skip) begin
            state <= ST_Q_UPD;
          end else if (!phase) begin
            phase <= 1'b1;
          end else begin
            state <= ST_M1;
          end
        end
        ST_Q_UPD: begin
          if (push) begin
            cnt <= cnt + 1'b1;
          end
          if (!phase) begin
            phase <= 1'b1;
            state <= ST_Q_RD;
          end else begin
            state <= ST_M1;
          end
        end
        ST_M1:  state <= ST_M1W;
        ST_M1W: state <= ST_M2;
        ST_M2:  state <= ST_M2W;
        ST_M2W: state <= ST_ACC;
        ST_ACC: begin
          acc <= sat_add(acc, mul_res);
          if (cnt == '0) begin
            ptr   <= '0;
            state <= ST_CLEAR;
          end else begin
            scan_i <= '0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (take_best) begin
            best_val <= alist_rd;
            best_pos <= scan_i[AW-1:0];
          end
          last <= alist_rd;
          if (scan_i == cnt - 1'b1) begin
            state <= ST_POP;
          end else begin
            scan_i <= scan_i + 1'b1;
          end
        end
        ST_POP: begin
          j     <= best_val;
          cnt   <= cnt - 1'b1;
          state <= ST_NODE_RD;
        end
        ST_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr == k) begin
            f     <= sat_add(acc, Q_MINUS_ONE);
            state <= ST_FIN_WRITE;
          end
        end
        ST_FIN_WRITE: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign ready          = (state == ST_IDLE);
  assign done           = (state == ST_DONE);
  assign res.row_index  = ROW_OUT_W'(k);
  assign res.f_value    = f;
  assign res.dii_value  = dii;
  assign res.bad_parent = bad;

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> (state == ST_PREP))
    else $error("accepted request did not start the sequencer");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> (cnt != '0))
    else $error("pop from an empty ancestor list");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_i < cnt))
    else $error("ancestor scan ran past the list");

  a_done_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && take) |=> (state == ST_IDLE))
    else $error("result handoff did not release the sequencer");

endmodule

`default_nettype wire

[test/tb_pedigree_inbreeding_coefficients.sv]
// Self-checking testbench for pedigree_inbreeding_coefficients: drives pedigree
// rows and register writes, predicts every result and compares it. Uses pic_pkg.
`timescale 1ns / 1ps

module tb_pedigree_inbreeding_coefficients;
  import pic_pkg::*;

  localparam int  ROWS      = 4096;
  localparam int  SLOTS     = 8192;
  localparam int  NO_PARENT = 4096;
  localparam int  WD_LIMIT  = 60000;
  localparam longint LMAX   = 64'sd2147483647;
  localparam longint LMIN   = -64'sd2147483648;
  localparam longint LONE   = 64'sd16777216;
  localparam longint LHALF  = 64'sd8388608;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic row_valid = 1'b0;
  logic row_stall;
  row_t row_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0] cfg_data = '0;

  int error_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  always #4 clk = ~clk;

  pedigree_inbreeding_coefficients u_top (
    .clk(clk), .rst(rst),
    .row_valid(row_valid), .row_stall(row_stall), .row_data(row_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Saturating Q8.24 arithmetic, carried in longint and clamped to 32 bits
  function automatic longint clamp32(input longint x);
    if (x > LMAX) return LMAX;
    if (x < LMIN) return LMIN;
    return x;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = (a * b) / LONE;  // signed division truncates toward zero
    return clamp32(p);
  endfunction

  class inbreeding_scoreboard;
    int unsigned dam_of[ROWS];
    int unsigned sire_of[ROWS];
    longint      f_of[ROWS];
    longint      dii_of[ROWS];
    longint      weight[ROWS];
    int unsigned anc[SLOTS];
    int unsigned row_ctr;
    int unsigned ind_count;
    int unsigned grp_count;
    bit          walk_on;
    longint      unk_f;
    res_t        pending_results[$];

    function new();
      row_ctr = 0;
      ind_count = 4096;
      grp_count = 0;
      walk_on = 1'b1;
      unk_f = -LONE;
      foreach (weight[i]) weight[i] = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] d);
      case (idx)
        CFG_INDIVIDUAL_COUNT: ind_count = 32'(d[IDX_IN_W-1:0]);
        CFG_GROUP_COUNT:      grp_count = 32'(d[GRP_W-1:0]);
        CFG_COMPUTE_F:        walk_on = d[0];
        CFG_UNKNOWN_PARENT_F: unk_f = longint'($signed(d));
        default: ;  // unused index: drop
      endcase
    endfunction

    function int unsigned next_row();
      int unsigned lim;
      lim = ind_count;
      if (lim < 1) lim = 1;
      if (lim > ROWS) lim = ROWS;
      return (row_ctr >= lim) ? 0 : row_ctr;
    endfunction

    function void add_ancestor(input int unsigned p, input int unsigned child,
                               inout int unsigned cnt);
      if (p == NO_PARENT || p < grp_count || p >= ROWS) return;
      weight[p] = clamp32(weight[p] + weight[child] / 2);
      for (int i = 0; i < cnt; i++) if (anc[i] == p) return;
      if (cnt < SLOTS) begin
        anc[cnt] = p;
        cnt++;
      end
    endfunction

    // Youngest-first (highest row first) ancestor walk with path weights
    function longint walk_f(input int unsigned k);
      longint acc;
      int unsigned j, cnt, best;
      acc = 0;
      j = k;
      cnt = 0;
      weight[k] = LONE;
      forever begin
        add_ancestor(sire_of[j], j, cnt);
        add_ancestor(dam_of[j], j, cnt);
        acc = clamp32(acc + qmul(qmul(weight[j], weight[j]), dii_of[j]));
        if (cnt == 0) break;
        best = 0;
        for (int i = 1; i < cnt; i++) if (anc[i] > anc[best]) best = i;
        j = anc[best];
        cnt--;
        anc[best] = anc[cnt];
      end
      for (int i = 0; i <= k; i++) weight[i] = 0;
      return clamp32(acc - LONE);
    endfunction

    function void note_row(input row_t r);
      int unsigned k, lim, dam, sire;
      bit bad;
      longint f, dii, fd, fs;
      res_t e;
      lim = ind_count;
      if (lim < 1) lim = 1;
      if (lim > ROWS) lim = ROWS;
      k = next_row();
      bad = 1'b0;
      if (k < grp_count) begin
        dam = NO_PARENT;
        sire = NO_PARENT;
        f = longint'(r.given_f);
        dii = 0;
      end else begin
        if (r.dam_index == ind_count) dam = NO_PARENT;
        else if (r.dam_index < k) dam = 32'(r.dam_index);
        else begin
          dam = NO_PARENT;
          bad = 1'b1;
        end
        if (r.sire_index == ind_count) sire = NO_PARENT;
        else if (r.sire_index < k) sire = 32'(r.sire_index);
        else begin
          sire = NO_PARENT;
          bad = 1'b1;
        end
        fd = (dam == NO_PARENT) ? unk_f : f_of[dam];
        fs = (sire == NO_PARENT) ? unk_f : f_of[sire];
        dii = clamp32(LHALF - clamp32(fd + fs) / 4);
        dam_of[k] = dam;
        sire_of[k] = sire;
        dii_of[k] = dii;
        if (!walk_on) f = longint'(r.given_f);
        else if (k > 0 && k - 1 >= grp_count && dam_of[k-1] == dam && sire_of[k-1] == sire)
          f = f_of[k-1];
        else f = walk_f(k);
      end
      dam_of[k] = dam;
      sire_of[k] = sire;
      f_of[k] = f;
      dii_of[k] = dii;
      row_ctr = (k + 1 >= lim) ? 0 : k + 1;
      e.row_index  = k[ROW_OUT_W-1:0];
      e.f_value    = f[VAL_W-1:0];
      e.dii_value  = dii[VAL_W-1:0];
      e.bad_parent = bad;
      pending_results.push_back(e);
    endfunction

    task check_result(input res_t got);
      res_t e;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result for row %0d", got.row_index));
        return;
      end
      e = pending_results.pop_front();
      if (got.row_index != e.row_index)
        flag_mismatch($sformatf("row_index %0d, want %0d", got.row_index, e.row_index));
      if (got.f_value !== e.f_value)
        flag_mismatch($sformatf("row %0d f_value %h, want %h", e.row_index,
                                got.f_value, e.f_value));
      if (got.dii_value !== e.dii_value)
        flag_mismatch($sformatf("row %0d dii_value %h, want %h", e.row_index,
                                got.dii_value, e.dii_value));
      if (got.bad_parent !== e.bad_parent)
        flag_mismatch($sformatf("row %0d bad_parent %b, want %b", e.row_index,
                                got.bad_parent, e.bad_parent));
    endtask
  endclass

  inbreeding_scoreboard sb = new();

  // Receiver: random stall, or a long hold-off when asked for one
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = 3000;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor results and count cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res_data);
    if ((res_valid && !res_stall) || (row_valid && !row_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin : watchdog
    while (idle_cycles < WD_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Write one register; caller sits at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input int ic, input int gc, input bit cf, input logic [31:0] upf);
    write_reg(CFG_INDIVIDUAL_COUNT, ic);
    write_reg(CFG_GROUP_COUNT, gc);
    write_reg(CFG_COMPUTE_F, 32'(cf));
    write_reg(CFG_UNKNOWN_PARENT_F, upf);
  endtask

  // Offer one request, hold it until accepted, then note it for prediction
  task automatic send_row(input logic [12:0] dam, input logic [12:0] sire,
                          input logic [31:0] gf);
    row_t r;
    r.dam_index = dam;
    r.sire_index = sire;
    r.given_f = gf;
    while ($urandom_range(99) < send_idle_pct) begin
      row_valid <= 1'b0;
      @(negedge clk);
    end
    row_valid <= 1'b1;
    row_data  <= r;
    do @(posedge clk); while (row_stall);
    sb.note_row(r);
    @(negedge clk);
  endtask

  // Wait until every expected result has come, then let the block settle
  task automatic drain();
    row_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [12:0] pick_parent(input int unsigned k, input int unsigned ic);
    int unsigned r, b, span;
    r = $urandom_range(99);
    if (k > 0 && r < 70) begin
      span = (k - 1 < 6) ? k - 1 : 6;
      if ($urandom_range(1)) return 13'(k - 1 - $urandom_range(span, 0));
      return 13'($urandom_range(k - 1, 0));
    end
    if (r < 85) return 13'(ic);
    b = $urandom_range(8191, k);
    if (b == ic) b = b + 1;
    return 13'(b);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return VMAX;
      1: return VMIN;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_rows(input int n);
    int unsigned k;
    logic [12:0] d, s, pd, ps;
    pd = 13'(sb.ind_count);
    ps = 13'(sb.ind_count);
    for (int i = 0; i < n; i++) begin
      k = sb.next_row();
      if ($urandom_range(99) < 20) begin
        d = pd;  // repeat the previous parents to hit the full-sib path
        s = ps;
      end else begin
        d = pick_parent(k, sb.ind_count);
        s = pick_parent(k, sb.ind_count);
      end
      send_row(d, s, pick_value());
      pd = d;
      ps = s;
    end
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 20; recv_stall_pct = 86; end
      1: begin send_idle_pct = 86; recv_stall_pct = 20; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  initial begin
    set_idle(2);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings, walk on, unknown parent -1.0
    send_row(13'd4096, 13'd4096, 32'h0);   // founder
    send_row(13'd4096, 13'd4096, 32'h0);   // founder
    send_row(13'd0, 13'd1, 32'h0);         // offspring of founders
    send_row(13'd0, 13'd1, 32'h0);         // full sib reuses f
    send_row(13'd2, 13'd3, 32'h0);         // sib mating
    send_row(13'd5, 13'd8191, 32'h0);      // both parents bad
    send_row(13'd4, 13'd2, 32'h0);         // back-cross
    drain();
    // Supplied values and extreme unknown-parent f
    write_reg(CFG_COMPUTE_F, 32'd0);
    write_reg(CFG_UNKNOWN_PARENT_F, VMAX);
    send_row(13'd4096, 13'd4096, VMAX);
    send_row(13'd4096, 13'd0, VMIN);
    drain();
    write_reg(CFG_UNKNOWN_PARENT_F, VMIN);
    send_row(13'd4096, 13'd4096, 32'h0);
    send_row(13'd7, 13'd8, 32'h1234_5678);
    drain();
    // Group rows: counter lies beyond the new limit, so rows restart at 0
    write_reg(8'hFF, 32'hFFFF_FFFF);      // unused index, ignored
    write_all(8, 3, 1'b1, Q_MINUS_ONE);
    send_row(13'd8191, 13'd5, VMAX);
    send_row(13'd0, 13'd0, VMIN);
    send_row(13'd4096, 13'd8, 32'h0080_0000);
    send_row(13'd0, 13'd1, 32'h0);        // group parents only
    send_row(13'd3, 13'd2, 32'h0);
    send_row(13'd4, 13'd3, 32'h0);
    send_row(13'd5, 13'd4, 32'h0);
    send_row(13'd6, 13'd6, 32'h0);        // last row, then wrap
    send_row(13'd8, 13'd8, VMAX);
    drain();

    // Random phases
    set_idle(0);
    write_all(24, 2, 1'b1, $urandom);
    random_rows(150);
    drain();

    set_idle(1);
    write_all(64, 0, 1'b1, 32'h0);
    hold_request = 1'b1;                  // long receiver hold-off fills the block
    set_idle(2);
    random_rows(40);
    set_idle(1);
    random_rows(110);
    drain();

    set_idle(2);
    write_all(1, 0, 1'b1, VMAX);
    random_rows(20);
    drain();

    set_idle(0);
    write_all(4096, 4095, 1'b1, VMIN);
    random_rows(20);
    drain();

    set_idle(1);
    write_reg(CFG_GROUP_COUNT, 5);
    random_rows(60);
    drain();

    set_idle(2);
    write_all(40, 0, 1'b0, 32'h0100_0000);
    random_rows(100);
    drain();

    set_idle(0);
    write_all(16, 15, 1'b1, $urandom);
    random_rows(60);
    drain();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
